FILE: hdl/sbrb_pkg.sv
// Package for the SPI slave byte ring buffers: ring depths, pointer widths,
// the opcode type and the record that carries an item to the result stage.
// No dependencies.
package sbrb_pkg;

    localparam int TX_DEPTH = 64;
    localparam int RX_DEPTH = 256;
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int BYTE_W   = 8;
    localparam int OP_W     = 2;
    localparam int FLAG_W   = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUT      = 2'd0,
        OP_GET      = 2'd1,
        OP_EXCHANGE = 2'd2
    } opcode_t;

    // What the result stage needs once the ring memory has returned its data.
    typedef struct packed {
        logic tx_sel;
        logic rx_sel;
        logic rx_available;
        logic tx_dropped;
        logic rx_overrun;
        logic rx_was_empty;
    } pend_t;

endpackage

FILE: hdl/sbrb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for both ring stores; no dependencies.
module sbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/spi_slave_byte_ring_buffers.sv
// Transmit and receive byte rings for an SPI slave, one RAM each.
// Depends on sbrb_pkg and sbrb_ram.
//
// One transaction on the slave side is a host put (queue a byte for transmit),
// a host get (pop a received byte) or an exchange (one finished SPI byte: pop
// the next transmit byte, 0x00 if none, and store the byte from the master).
// Each ring keeps one slot empty, so the transmit ring holds up to 63 bytes and
// the receive ring up to 255. A put on a full transmit ring is dropped and
// flagged; an exchange on a full receive ring writes its byte to the spare
// slot without advancing, so it is lost, and flags an overrun; a get on an
// empty receive ring returns 0 and is flagged. Every input transaction gives
// exactly one result. The ring pointers live in registers and are updated in
// the cycle of acceptance, while the ring RAM is read; the result is offered
// on the master side from the output register, fed by the registered RAM
// read. The block sustains one transaction per cycle while the master side
// takes results, and holds one further transaction while a result waits.
module spi_slave_byte_ring_buffers (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_in
    input  logic [1:0] s_tuser,   // [1:0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_out
    output logic [3:0] m_tuser    // [0] rx_available, [1] tx_dropped,
                                  // [2] rx_overrun, [3] rx_was_empty
);

    logic [sbrb_pkg::TX_AW-1:0] tx_wr_reg, tx_wr_next, tx_rd_reg, tx_rd_next;
    logic [sbrb_pkg::RX_AW-1:0] rx_wr_reg, rx_wr_next, rx_rd_reg, rx_rd_next;
    logic [sbrb_pkg::TX_AW-1:0] tx_wr_inc, tx_rd_inc;
    logic [sbrb_pkg::RX_AW-1:0] rx_wr_inc, rx_rd_inc;
    logic                       tx_empty, tx_full, rx_empty, rx_full;

    logic                       tx_we, tx_re, rx_we, rx_re;
    logic [sbrb_pkg::BYTE_W-1:0] tx_rdata, rx_rdata;

    sbrb_pkg::opcode_t          op;
    sbrb_pkg::pend_t            pend_reg, pend_next;
    logic                       pend_valid_reg;
    logic                       s_accept, out_load;

    logic                        m_tvalid_reg;
    logic [sbrb_pkg::BYTE_W-1:0] m_data_reg;
    logic [sbrb_pkg::FLAG_W-1:0] m_flags_reg;

    assign op       = sbrb_pkg::opcode_t'(s_tuser);
    assign out_load = pend_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !pend_valid_reg || out_load;
    assign s_accept = s_tvalid && s_tready;

    // Depths need not be powers of two, so the pointers wrap explicitly.
    assign tx_wr_inc = (tx_wr_reg == sbrb_pkg::TX_AW'(sbrb_pkg::TX_DEPTH - 1)) ?
                       '0 : tx_wr_reg + 1'b1;
    assign tx_rd_inc = (tx_rd_reg == sbrb_pkg::TX_AW'(sbrb_pkg::TX_DEPTH - 1)) ?
                       '0 : tx_rd_reg + 1'b1;
    assign rx_wr_inc = (rx_wr_reg == sbrb_pkg::RX_AW'(sbrb_pkg::RX_DEPTH - 1)) ?
                       '0 : rx_wr_reg + 1'b1;
    assign rx_rd_inc = (rx_rd_reg == sbrb_pkg::RX_AW'(sbrb_pkg::RX_DEPTH - 1)) ?
                       '0 : rx_rd_reg + 1'b1;

    assign tx_empty = (tx_wr_reg == tx_rd_reg);
    assign tx_full  = (tx_wr_inc == tx_rd_reg);
    assign rx_empty = (rx_wr_reg == rx_rd_reg);
    assign rx_full  = (rx_wr_inc == rx_rd_reg);

    always_comb begin
        tx_wr_next = tx_wr_reg;
        tx_rd_next = tx_rd_reg;
        rx_wr_next = rx_wr_reg;
        rx_rd_next = rx_rd_reg;
        tx_we      = 1'b0;
        tx_re      = 1'b0;
        rx_we      = 1'b0;
        rx_re      = 1'b0;
        pend_next  = '0;
        if (s_accept) begin
            case (op)
                sbrb_pkg::OP_PUT: begin
                    if (!tx_full) begin
                        tx_we      = 1'b1;
                        tx_wr_next = tx_wr_inc;
                    end else begin
                        pend_next.tx_dropped = 1'b1;
                    end
                end
                sbrb_pkg::OP_GET: begin
                    if (!rx_empty) begin
                        rx_re            = 1'b1;
                        rx_rd_next       = rx_rd_inc;
                        pend_next.rx_sel = 1'b1;
                    end else begin
                        pend_next.rx_was_empty = 1'b1;
                    end
                end
                sbrb_pkg::OP_EXCHANGE: begin
                    if (!tx_empty) begin
                        tx_re            = 1'b1;
                        tx_rd_next       = tx_rd_inc;
                        pend_next.tx_sel = 1'b1;
                    end
                    // The received byte is always written; on a full ring it
                    // lands in the spare slot without advancing and is lost.
                    rx_we = 1'b1;
                    if (!rx_full) begin
                        rx_wr_next = rx_wr_inc;
                    end else begin
                        pend_next.rx_overrun = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        pend_next.rx_available = (rx_wr_next != rx_rd_next);
    end

    sbrb_ram #(
        .WIDTH(sbrb_pkg::BYTE_W),
        .DEPTH(sbrb_pkg::TX_DEPTH)
    ) u_tx_ram (
        .aclk   (aclk),
        .wr_en  (tx_we),
        .wr_addr(tx_wr_reg),
        .wr_data(s_tdata),
        .rd_en  (tx_re),
        .rd_addr(tx_rd_reg),
        .rd_data(tx_rdata)
    );

    sbrb_ram #(
        .WIDTH(sbrb_pkg::BYTE_W),
        .DEPTH(sbrb_pkg::RX_DEPTH)
    ) u_rx_ram (
        .aclk   (aclk),
        .wr_en  (rx_we),
        .wr_addr(rx_wr_reg),
        .wr_data(s_tdata),
        .rd_en  (rx_re),
        .rd_addr(rx_rd_reg),
        .rd_data(rx_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_wr_reg      <= '0;
            tx_rd_reg      <= '0;
            rx_wr_reg      <= '0;
            rx_rd_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            tx_wr_reg <= tx_wr_next;
            tx_rd_reg <= tx_rd_next;
            rx_wr_reg <= rx_wr_next;
            rx_rd_reg <= rx_rd_next;
            if (s_accept) begin
                pend_valid_reg <= 1'b1;
            end else if (out_load) begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // The RAM read data holds until the next read, which only comes with the
    // next accepted transaction, so a stalled item still sees its own byte.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pend_reg <= pend_next;
        end
        if (out_load) begin
            m_data_reg  <= pend_reg.tx_sel ? tx_rdata :
                           (pend_reg.rx_sel ? rx_rdata : '0);
            m_flags_reg <= {pend_reg.rx_was_empty, pend_reg.rx_overrun,
                            pend_reg.tx_dropped, pend_reg.rx_available};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_flags_reg;

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid_reg && !pend_valid_reg)
        else $error("result stages not cleared by reset");

    a_one_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> $onehot0(m_flags_reg[3:1]))
        else $error("more than one exception flag in a result");

    a_get_empty_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (op == sbrb_pkg::OP_GET) && rx_empty
        |=> $stable(rx_rd_reg) && $stable(rx_wr_reg))
        else $error("get on an empty receive ring moved a pointer");

    a_pend_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg && !out_load
        |=> pend_valid_reg && $stable(pend_reg) && $stable(tx_rdata)
            && $stable(rx_rdata))
        else $error("stalled transaction lost its pending data");

endmodule
